@@ hdl/fbfla_pkg.sv @@
// Types and constants shared by the block free-list allocator and its checker.
`timescale 1ns / 1ps

package fbfla_pkg;

    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int BB_W     = 17;
    localparam int STRIDE_W = 18;
    localparam int PROD_W   = 29;
    localparam int ADDR_W   = 32;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam int MAX_BLOCKS      = 1024;
    localparam int ALIGN_BYTES     = 8;
    localparam int MIN_BLOCK_BYTES = 8;

    localparam logic [CNT_W-1:0] FREE_SAT = 11'd2047;

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_CONTAINS = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_POOL_BASE   = 2'd0,
        REG_BLOCK_BYTES = 2'd1,
        REG_BLOCK_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_req_type         req_type;
        logic [IDX_W-1:0]  block_index;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  result_index;
        logic [ADDR_W-1:0] result_address;
        t_status           status;
        logic [CNT_W-1:0]  free_count;
        logic              in_pool;
    } t_out_item;

endpackage

@@ hdl/fixed_block_free_list_allocator.sv @@
// Fixed-size block allocator: LIFO free list held in a link memory.
`timescale 1ns / 1ps

// The pool is a LIFO list of block indices chained through a single-port-write,
// registered-read link memory of MAX_BLOCKS entries, plus a head index and a free
// count in flip-flops. Every request gives one result. Free, a rejected free and
// an alloc on an empty pool give their result from the idle state; a successful
// alloc and a contains check pass first through S_ALLOC or S_CONT (the link memory
// read of the head, and the stride multiply before the add); clear rebuilds
// min(block_count, MAX_BLOCKS) blocks, one link write per block rebuilt.
// The link memory is not cleared at reset: issue a clear before the first alloc.
// The block stride is max(block_bytes, 8) rounded up to a multiple of 8 and is
// worked out when block_bytes is written. Register writes do not rebuild the list.
module fixed_block_free_list_allocator
    import fbfla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int LW = $clog2(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALLOC = 4'b0010,
        S_CONT  = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    function automatic logic [STRIDE_W-1:0] round_stride(input logic [BB_W-1:0] bytes);
        logic [STRIDE_W-1:0] s;
        s = (bytes < BB_W'(MIN_BLOCK_BYTES)) ? STRIDE_W'(MIN_BLOCK_BYTES) : {1'b0, bytes};
        return (s + STRIDE_W'(ALIGN_BYTES - 1)) & ~STRIDE_W'(ALIGN_BYTES - 1);
    endfunction

    // configuration
    logic [ADDR_W-1:0]   r_pool_base;
    logic [BB_W-1:0]     r_block_bytes;
    logic [CNT_W-1:0]    r_block_count;
    logic [STRIDE_W-1:0] r_stride;
    logic                cfg_wr;

    // list state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic                r_head_valid, n_head_valid;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_ctr, n_ctr;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PROD_W-1:0]   r_prod, n_prod;

    // link memory
    logic [IDX_W-1:0]    r_link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]    r_link_rdata;
    logic                mem_we, mem_re;
    logic [LW-1:0]       mem_waddr, mem_raddr;
    logic [IDX_W-1:0]    mem_wdata;

    // result and output stages
    t_out_item           r_res, n_res;
    logic                r_res_valid, n_res_valid;
    t_out_item           r_out;
    logic                r_out_valid;

    logic                in_accept, out_free, produce;
    logic [CNT_W-1:0]    cnt_use, free_inc;
    logic [CNT_W-1:0]    mul_a;
    logic [PROD_W-1:0]   product;
    logic [ADDR_W:0]     pool_limit;
    t_out_item           res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_block_bytes <= BB_W'(8);
            r_block_count <= CNT_W'(1024);
            r_stride      <= round_stride(BB_W'(8));
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_POOL_BASE:   r_pool_base <= pwdata;
                REG_BLOCK_BYTES: begin
                    r_block_bytes <= pwdata[BB_W-1:0];
                    r_stride      <= round_stride(pwdata[BB_W-1:0]);
                end
                REG_BLOCK_COUNT: r_block_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POOL_BASE:   prdata = r_pool_base;
            REG_BLOCK_BYTES: prdata = PDATA_W'(r_block_bytes);
            REG_BLOCK_COUNT: prdata = PDATA_W'(r_block_count);
            default:         prdata = '0;
        endcase
    end

    assign cnt_use  = (32'(r_block_count) < 32'(MAX_BLOCKS)) ? r_block_count
                                                              : CNT_W'(MAX_BLOCKS);
    assign free_inc = (r_free == FREE_SAT) ? r_free : r_free + CNT_W'(1);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_res_valid && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign mul_a      = (i_in_data.req_type == REQ_CONTAINS) ? cnt_use : {1'b0, r_head};
    assign product    = {{(PROD_W-CNT_W){1'b0}}, mul_a} * {{(PROD_W-STRIDE_W){1'b0}}, r_stride};
    assign pool_limit = {1'b0, r_pool_base} + (ADDR_W+1)'(r_prod);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_free       = r_free;
        n_ctr        = r_ctr;
        n_idx        = r_idx;
        n_addr       = r_addr;
        n_prod       = r_prod;
        produce      = 1'b0;
        res          = '0;
        res.status   = ST_OK;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = LW'(r_ctr);
        mem_raddr    = LW'(r_head);
        mem_wdata    = r_head_valid ? r_head : '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_prod = product;
                    n_addr = i_in_data.address;
                    case (i_in_data.req_type)
                        REQ_ALLOC: begin
                            if (!r_head_valid || r_free == '0) begin
                                produce        = 1'b1;
                                res.status     = ST_EMPTY;
                                res.free_count = r_free;
                            end else begin
                                mem_re  = 1'b1;
                                n_idx   = r_head;
                                n_state = S_ALLOC;
                            end
                        end
                        REQ_FREE: begin
                            produce = 1'b1;
                            if ({1'b0, i_in_data.block_index} >= cnt_use) begin
                                res.status     = ST_BAD_INDEX;
                                res.free_count = r_free;
                            end else begin
                                mem_we         = 1'b1;
                                mem_waddr      = LW'(i_in_data.block_index);
                                n_head         = i_in_data.block_index;
                                n_head_valid   = 1'b1;
                                n_free         = free_inc;
                                res.free_count = free_inc;
                            end
                        end
                        REQ_CLEAR: begin
                            n_head       = '0;
                            n_head_valid = 1'b0;
                            n_free       = '0;
                            n_ctr        = '0;
                            n_state      = S_CLEAR;
                        end
                        REQ_CONTAINS: n_state = S_CONT;
                        default: ;
                    endcase
                end
            end
            S_ALLOC: begin
                // pop: the head's link entry becomes the new head
                n_head             = r_link_rdata;
                n_free             = r_free - CNT_W'(1);
                if (r_free == CNT_W'(1))
                    n_head_valid   = 1'b0;
                produce            = 1'b1;
                res.result_index   = r_idx;
                res.result_address = r_pool_base + ADDR_W'(r_prod);
                res.free_count     = n_free;
                n_state            = S_IDLE;
            end
            S_CONT: begin
                produce        = 1'b1;
                res.in_pool    = (r_addr >= r_pool_base) && ({1'b0, r_addr} < pool_limit);
                res.free_count = r_free;
                n_state        = S_IDLE;
            end
            S_CLEAR: begin
                if (r_ctr == cnt_use) begin
                    produce        = 1'b1;
                    res.free_count = r_free;
                    n_state        = S_IDLE;
                end else begin
                    // push blocks in ascending order, one link write a cycle
                    mem_we       = 1'b1;
                    n_head       = r_ctr[IDX_W-1:0];
                    n_head_valid = 1'b1;
                    n_free       = free_inc;
                    n_ctr        = r_ctr + CNT_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a result only lands in the holding stage when it is empty or draining
        n_res_valid = produce || (r_res_valid && !out_free);
        n_res       = produce ? res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            r_link_rdata <= r_link_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_free       <= '0;
            r_ctr        <= '0;
            r_res_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_free       <= n_free;
            r_ctr        <= n_ctr;
            r_res_valid  <= n_res_valid;
            if (out_free)
                r_out_valid <= r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_prod <= n_prod;
        r_res  <= n_res;
        if (out_free && r_res_valid)
            r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/fbfla_checker.sv @@
// Port-level checks for the block free-list allocator, bound to the top level.
`timescale 1ns / 1ps

module fbfla_checker
    import fbfla_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty pool gives no block
    a_empty_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |->
            o_out_data.result_index == '0 && o_out_data.result_address == '0)
        else $error("block given on empty pool");

    // a contains hit comes only from a contains check
    a_in_pool_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.in_pool |->
            o_out_data.status == ST_OK && o_out_data.result_index == '0 &&
            o_out_data.result_address == '0)
        else $error("in_pool set on a non-contains result");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
